@@ design/mersenne_twister_32_defines.svh @@
// assertion macros for the mt19937 block
`ifndef MERSENNE_TWISTER_32_DEFINES_SVH
`define MERSENNE_TWISTER_32_DEFINES_SVH

// same-cycle implication
`define MT32_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MT32_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mt32_pkg.sv @@
package mt32_pkg;

	localparam int WordW         = 32;
	localparam int StateWordsDef = 624;
	localparam int ShiftM        = 397;

	localparam logic [WordW-1:0] SeedMult = 32'd1812433253;
	localparam logic [WordW-1:0] MatrixA  = 32'h9908_B0DF;
	localparam logic [WordW-1:0] TemperB  = 32'h9D2C_5680;
	localparam logic [WordW-1:0] TemperC  = 32'hEFC6_0000;

	localparam logic CmdNext = 1'b0;
	localparam logic CmdSeed = 1'b1;

	function automatic logic [WordW-1:0] twist(
		input logic [WordW-1:0] cur,
		input logic [WordW-1:0] nxt,
		input logic [WordW-1:0] mid
	);
		logic [WordW-1:0] pair;
		pair = {cur[WordW-1], nxt[WordW-2:0]};
		return mid ^ (pair >> 1) ^ (pair[0] ? MatrixA : '0);
	endfunction

	function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] y_in);
		logic [WordW-1:0] y;
		y = y_in;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TemperB);
		y = y ^ ((y << 15) & TemperC);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

@@ design/mersenne_twister_32.sv @@
// MT19937 32-bit generator. A next item (cmd 0) is taken every cycle while the output
// register is empty or being read; its tempered word is loaded into the output register
// at the transfer and shows in the cycle after. The 624 x 32 state memory has one write
// port and two registered read ports that always hold the word after the current index
// and the word 397 ahead, and the current word is kept in a register, so back-to-back
// next items run at one per cycle while out_ready stays high. A seed item (cmd 1) gives
// no result; after its transfer the block takes no input while the seeding recurrence
// writes one word per cycle through the single multiplier and the memory write port.
// Next items before the first seed return undefined values.
`include "mersenne_twister_32_defines.svh"

module mersenne_twister_32 #(
	parameter int STATE_WORDS = mt32_pkg::StateWordsDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cmd,
	input  logic [mt32_pkg::WordW-1:0] seed_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mt32_pkg::WordW-1:0] random_word
);
	import mt32_pkg::*;

	localparam int IdxW = $clog2(STATE_WORDS);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(STATE_WORDS - 1);
	localparam logic [IdxW:0] NWords = (IdxW+1)'(STATE_WORDS);
	localparam logic [IdxW:0] ShiftMExt = (IdxW+1)'(ShiftM);

	localparam logic StRun  = 1'b0;
	localparam logic StSeed = 1'b1;

	function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] i);
		return (i == LastIdx) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IdxW-1:0] idx_mid(input logic [IdxW-1:0] i);
		logic [IdxW:0] sum;
		sum = {1'b0, i} + ShiftMExt;
		if (sum >= NWords) begin
			sum = sum - NWords;
		end
		return sum[IdxW-1:0];
	endfunction

	logic [WordW-1:0] twist_words_q [STATE_WORDS];

	logic             state_q;
	logic             state_d;
	logic [IdxW-1:0]  idx_q;
	logic [IdxW-1:0]  idx_d;
	logic [IdxW-1:0]  idx_nxt;
	logic [IdxW-1:0]  seed_cnt_q;
	logic [WordW-1:0] prev_q;
	logic [WordW-1:0] cur_q;
	logic [WordW-1:0] rd_nxt_q;
	logic [WordW-1:0] rd_mid_q;
	logic             out_valid_q;
	logic [WordW-1:0] random_word_q;

	logic             in_xfer;
	logic             next_xfer;
	logic             seed_xfer;
	logic [WordW-1:0] seed_mix;
	logic [WordW-1:0] seed_word;
	logic [WordW-1:0] twisted;
	logic             wr_en;
	logic [IdxW-1:0]  wr_addr;
	logic [WordW-1:0] wr_data;

	assign in_ready  = (state_q == StRun) && (!out_valid_q || out_ready);
	assign in_xfer   = in_valid && in_ready;
	assign next_xfer = in_xfer && (cmd == CmdNext);
	assign seed_xfer = in_xfer && (cmd == CmdSeed);

	assign idx_nxt  = idx_inc(idx_q);
	assign seed_mix = prev_q ^ (prev_q >> 30);
	assign seed_word = seed_mix * SeedMult + WordW'(seed_cnt_q);
	assign twisted  = twist(cur_q, rd_nxt_q, rd_mid_q);

	always_comb begin
		idx_d = idx_q;
		if (seed_xfer) begin
			idx_d = '0;
		end else if (next_xfer) begin
			idx_d = idx_nxt;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			StRun: begin
				if (seed_xfer) begin
					state_d = StSeed;
				end
			end
			StSeed: begin
				if (seed_cnt_q == LastIdx) begin
					state_d = StRun;
				end
			end
			default: state_d = StRun;
		endcase
	end

	// single write port shared by seeding and twisting
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = twisted;
		if (state_q == StSeed) begin
			wr_en   = 1'b1;
			wr_addr = seed_cnt_q;
			wr_data = seed_word;
		end else if (seed_xfer) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = seed_value;
		end else if (next_xfer) begin
			wr_en = 1'b1;
		end
	end

	// reads prefetch the words needed by the index after this edge
	always_ff @(posedge clk) begin
		if (wr_en) begin
			twist_words_q[wr_addr] <= wr_data;
		end
		rd_nxt_q <= twist_words_q[idx_inc(idx_d)];
		rd_mid_q <= twist_words_q[idx_mid(idx_d)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StRun;
			idx_q       <= '0;
			seed_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (seed_xfer) begin
				seed_cnt_q <= IdxW'(1);
			end else if (state_q == StSeed) begin
				seed_cnt_q <= seed_cnt_q + 1'b1;
			end
			if (next_xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seed_xfer) begin
			prev_q <= seed_value;
			cur_q  <= seed_value;
		end else if (state_q == StSeed) begin
			prev_q <= seed_word;
		end else if (next_xfer) begin
			cur_q <= rd_nxt_q;
		end
		if (next_xfer) begin
			random_word_q <= temper(twisted);
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;

	`MT32_ASSERT_IMPL(a_seed_blocks_input, state_q == StSeed, !in_ready, "input taken while seeding")
	`MT32_ASSERT_NEXT(a_seed_ends_at_zero, (state_q == StSeed) && (seed_cnt_q == LastIdx), (state_q == StRun) && (idx_q == '0), "seeding did not end at index zero")
	`MT32_ASSERT_NEXT(a_next_gives_result, next_xfer, out_valid, "next transfer gave no result")
	`MT32_ASSERT_NEXT(a_index_advances, next_xfer, idx_q == $past(idx_nxt), "index did not advance")

endmodule

@@ tb/mersenne_twister_32_test.sv @@
`timescale 1ns / 1ps

module mersenne_twister_32_test;
	import mt32_pkg::*;

	class twister_mirror;
		logic [WordW-1:0] words [StateWordsDef];
		int unsigned pos;
		logic [WordW-1:0] expected_words [$];
		int errors;

		function new();
			foreach (words[i]) words[i] = '0;
			pos = 0;
			errors = 0;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		// one accepted input transfer
		function void note_transfer(logic op, logic [WordW-1:0] seed);
			int unsigned nx;
			int unsigned far;
			logic [WordW-1:0] joined;
			logic [WordW-1:0] fresh;
			logic [WordW-1:0] t;
			if (op == CmdSeed) begin
				words[0] = seed;
				for (int unsigned i = 1; i < StateWordsDef; i++) begin
					words[i] = (words[i-1] ^ (words[i-1] >> 30)) * SeedMult + i;
				end
				pos = 0;
				return;
			end
			nx = (pos == StateWordsDef - 1) ? 0 : pos + 1;
			far = pos + ShiftM;
			if (far >= StateWordsDef) far = far - StateWordsDef;
			joined = {words[pos][WordW-1], words[nx][WordW-2:0]};
			fresh = words[far] ^ (joined >> 1) ^ (joined[0] ? MatrixA : '0);
			words[pos] = fresh;
			pos = nx;
			t = fresh;
			t = t ^ (t >> 11);
			t = t ^ ((t << 7) & TemperB);
			t = t ^ ((t << 15) & TemperC);
			t = t ^ (t >> 18);
			expected_words.push_back(t);
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_word(logic [WordW-1:0] got);
			logic [WordW-1:0] want;
			if (expected_words.size() == 0) begin
				report($sformatf("random_word %h with nothing expected", got));
				return;
			end
			want = expected_words.pop_front();
			if (got !== want) begin
				report($sformatf("random_word %h, expected %h", got, want));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic cmd;
	logic [WordW-1:0] seed_value;
	logic out_valid;
	logic out_ready;
	logic [WordW-1:0] random_word;

	bit calm = 1'b0;
	twister_mirror board = new();

	mersenne_twister_32 uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.seed_value(seed_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.random_word(random_word)
	);

	always #2 clk = ~clk;

	// input transfer noted before output check so any same-edge result finds its expectation
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			board.note_transfer(cmd, seed_value);
		end
		if (arst_n && out_valid && out_ready) begin
			board.check_word(random_word);
		end
	end

	task automatic send_item(input logic op, input logic [WordW-1:0] seed);
		in_valid <= 1'b1;
		cmd <= op;
		seed_value <= seed;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic rest_input(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	// receiver side
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 200 : 20)) @(posedge clk);
		end
	end

	initial begin
		int sent;
		int run_len;
		int idle_pct;
		logic [WordW-1:0] seed;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CmdNext;
		seed_value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: seed extremes, known seed, alternating bits, ignored seed field
		send_item(CmdSeed, 32'h0000_0000);
		repeat (3) send_item(CmdNext, $urandom);
		send_item(CmdSeed, 32'hFFFF_FFFF);
		send_item(CmdNext, 32'hFFFF_FFFF);
		send_item(CmdNext, 32'h0000_0000);
		send_item(CmdNext, $urandom);
		send_item(CmdSeed, 32'd5489);
		repeat (3) send_item(CmdNext, $urandom);
		send_item(CmdSeed, 32'hAAAA_AAAA);
		repeat (2) send_item(CmdNext, $urandom);
		send_item(CmdSeed, 32'h5555_5555);
		repeat (2) send_item(CmdNext, $urandom);
		drain_results();

		// random: seeded runs of next items, the first long enough to wrap the index
		sent = 0;
		while (sent < 1100) begin
			calm = (sent >= 950);
			idle_pct = calm ? 0 : $urandom_range(0, 2) * 15;
			if (!calm && $urandom_range(0, 3) == 0) drain_results();
			case ($urandom_range(0, 7))
				0: seed = '0;
				1: seed = '1;
				default: seed = $urandom;
			endcase
			send_item(CmdSeed, seed);
			sent++;
			run_len = (sent == 1) ? 700 : $urandom_range(1, 150);
			repeat (run_len) begin
				if ($urandom_range(1, 100) <= idle_pct) rest_input($urandom_range(1, 15));
				send_item(CmdNext, $urandom);
				sent++;
			end
		end

		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
